// ----- hdl/htn_pkg.sv -----
package htn_pkg;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD1,
    ST_LOAD2,
    ST_PREP,
    ST_DIV,
    ST_SQRT,
    ST_MUL,
    ST_EMIT
  } htn_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;
    logic load1;
    logic load2;
    logic prep;
    logic div_step;
    logic sqrt_step;
    logic mul;
    logic emit;
  } htn_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic row_zero;
    logic div_last;
    logic sqrt_last;
    logic more;
    logic out_free;
  } htn_sts_t;

  // Register indexes of the configuration port.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 2'd1;
  localparam logic [7:0] CFG_SIZE_RESET = 8'd32;
  localparam int unsigned MIN_SIZE = 4;

  // k = round(2^16 * 255 / sqrt(s)) is found as isqrt(LIM / s), with
  // LIM = 4 * (255 * 2^16)^2 = 65025 * 2^34.
  localparam int unsigned NORM_BASE = 65025;
  localparam logic [49:0] LIM = 50'(NORM_BASE) << 34;
  localparam int unsigned DIV_STEPS  = 35;
  localparam int unsigned SQRT_STEPS = 18;
  localparam logic [17:0] DIV_REM_INIT = 18'(LIM[49:35]);
  localparam logic [34:0] DIV_LOW_BITS = LIM[34:0];
  localparam int unsigned NORM_BIAS = 16711680;

endpackage

// ----- hdl/htn_ram.sv -----
module htn_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/htn_ctrl.sv -----
module htn_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  htn_pkg::htn_sts_t sts_i,
  output htn_pkg::htn_cmd_t cmd_o
);
  import htn_pkg::*;

  htn_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && !sts_i.row_zero) state_d = ST_LOAD1;
      end
      ST_LOAD1: state_d = ST_LOAD2;
      ST_LOAD2: state_d = ST_PREP;
      ST_PREP:  state_d = ST_DIV;
      ST_DIV: begin
        if (sts_i.div_last) state_d = ST_SQRT;
      end
      ST_SQRT: begin
        if (sts_i.sqrt_last) state_d = ST_MUL;
      end
      ST_MUL:   state_d = ST_EMIT;
      ST_EMIT: begin
        if (sts_i.out_free) state_d = sts_i.more ? ST_PREP : ST_IDLE;
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o           = '0;
    in_ready_o      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.take = in_valid_i;
      end
      ST_LOAD1: cmd_o.load1     = 1'b1;
      ST_LOAD2: cmd_o.load2     = 1'b1;
      ST_PREP:  cmd_o.prep      = 1'b1;
      ST_DIV:   cmd_o.div_step  = 1'b1;
      ST_SQRT:  cmd_o.sqrt_step = 1'b1;
      ST_MUL:   cmd_o.mul       = 1'b1;
      ST_EMIT:  cmd_o.emit      = sts_i.out_free;
      default:  cmd_o           = '0;
    endcase
  end

endmodule

// ----- hdl/htn_dp.sv -----
module htn_dp #(
  parameter int unsigned MaxSize = 128
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [htn_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [7:0]                      cfg_data_i,
  input  logic [7:0]                      height_i,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic [7:0]                      normal_x_o,
  output logic [7:0]                      normal_y_o,
  output logic [7:0]                      normal_z_o,
  output logic                            last_of_run_o,
  output logic                            end_of_frame_o,
  input  htn_pkg::htn_cmd_t               cmd_i,
  output htn_pkg::htn_sts_t               sts_o
);
  import htn_pkg::*;

  localparam int unsigned AW = $clog2(MaxSize);
  localparam int unsigned SW = $clog2(MaxSize + 1);
  localparam int unsigned CW = (SW > 8) ? SW : 8;

  // Configuration and position.
  logic [7:0]    width_q, height_q;
  logic [AW-1:0] x_q, x_d, y_q, y_d;
  logic [CW-1:0] w, h, xe, ye, xc, yc, xn, yn;
  logic [AW-1:0] xa;
  logic          last_row, at_left, at_right, advance;

  function automatic logic [CW-1:0] sat_size(input logic [7:0] v);
    logic [CW-1:0] e;
    e = CW'(v);
    if (e < CW'(MIN_SIZE)) return CW'(MIN_SIZE);
    if (e > CW'(MaxSize)) return CW'(MaxSize);
    return e;
  endfunction

  assign w  = sat_size(width_q);
  assign h  = sat_size(height_q);
  assign xe = CW'(x_q);
  assign ye = CW'(y_q);
  assign xc = (xe >= w) ? w - CW'(1) : xe;
  assign yc = (ye >= h) ? h - CW'(1) : ye;
  assign xa = AW'(xc);
  assign xn = xc + CW'(1);
  assign yn = yc + CW'(1);
  assign last_row = (yc == h - CW'(1));
  assign at_left  = (xc == '0);
  assign at_right = (xc == w - CW'(1));
  assign advance  = (cmd_i.take && sts_o.row_zero) || cmd_i.load2;

  always_comb begin
    x_d = x_q;
    y_d = y_q;
    if (advance) begin
      if (xn >= w) begin
        x_d = '0;
        y_d = (yn >= h) ? '0 : AW'(yn);
      end else begin
        x_d = AW'(xn);
        y_d = AW'(yc);
      end
    end
    if (cfg_we_i && (cfg_index_i == CFG_IDX_WIDTH || cfg_index_i == CFG_IDX_HEIGHT)) begin
      x_d = '0;
      y_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CFG_SIZE_RESET;
      height_q <= CFG_SIZE_RESET;
      x_q      <= '0;
      y_q      <= '0;
    end else begin
      x_q <= x_d;
      y_q <= y_d;
      if (cfg_we_i && cfg_index_i == CFG_IDX_WIDTH)  width_q  <= cfg_data_i;
      if (cfg_we_i && cfg_index_i == CFG_IDX_HEIGHT) height_q <= cfg_data_i;
    end
  end

  // Line stores.
  logic          new_we;
  logic [7:0]    new_wdata, new_rdata, old_rdata;
  logic [AW-1:0] new_raddr;
  logic [7:0]    v_q, c_q, upraw_q, prevc_q, pv1_q, pv2_q;

  assign new_we    = (cmd_i.take && sts_o.row_zero) || cmd_i.load2;
  assign new_wdata = cmd_i.load2 ? v_q : height_i;
  assign new_raddr = cmd_i.load1 ? AW'(xc + CW'(1)) : xa;

  htn_ram #(.Width(8), .Depth(MaxSize)) u_newer (
    .clk_i   (clk_i),
    .we_i    (new_we),
    .waddr_i (xa),
    .wdata_i (new_wdata),
    .raddr_i (new_raddr),
    .rdata_o (new_rdata)
  );

  htn_ram #(.Width(8), .Depth(MaxSize)) u_older (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load2),
    .waddr_i (xa),
    .wdata_i (c_q),
    .raddr_i (xa),
    .rdata_o (old_rdata)
  );

  // Result slots: up to three gradient pairs per item.
  logic signed [8:0] dx_q [3];
  logic signed [8:0] dy_q [3];
  logic [2:0]        eof_q;
  logic [1:0]        n_q, slot_q;
  logic [7:0]        lf, rt, up, ll;
  logic              has1, has2;

  function automatic logic signed [8:0] diff(input logic [7:0] a, input logic [7:0] b);
    return $signed({1'b0, a}) - $signed({1'b0, b});
  endfunction

  assign lf   = at_left ? c_q : prevc_q;
  assign rt   = at_right ? c_q : new_rdata;
  assign up   = (yc == CW'(1)) ? c_q : upraw_q;
  assign ll   = (xc == CW'(1)) ? pv1_q : pv2_q;
  assign has1 = last_row && !at_left;
  assign has2 = last_row && at_right;

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      v_q <= height_i;
    end
    if (cmd_i.take && sts_o.row_zero) begin
      pv1_q <= height_i;
      pv2_q <= pv1_q;
    end
    if (cmd_i.load1) begin
      c_q     <= new_rdata;
      upraw_q <= old_rdata;
    end
    if (cmd_i.load2) begin
      dx_q[0] <= diff(lf, rt);
      dy_q[0] <= diff(up, v_q);
      dx_q[1] <= diff(ll, v_q);
      dy_q[1] <= diff(prevc_q, pv1_q);
      dx_q[2] <= diff(pv1_q, v_q);
      dy_q[2] <= diff(c_q, v_q);
      eof_q   <= 3'b100;
      n_q     <= 2'd1 + 2'(has1) + 2'(has2);
      prevc_q <= c_q;
      pv1_q   <= v_q;
      pv2_q   <= pv1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else if (cmd_i.load2) begin
      slot_q <= '0;
    end else if (cmd_i.emit) begin
      slot_q <= slot_q + 2'd1;
    end
  end

  // Normalization: k = (isqrt(LIM / s) + 1) / 2, one quotient bit or one
  // root bit per cycle.
  logic signed [8:0]  dx_s, dy_s;
  logic signed [17:0] dx_e, dy_e;
  logic [17:0]        s_q, rem_q;
  logic [34:0]        dd_q;
  logic [35:0]        q_q;
  logic [17:0]        root_q;
  logic [18:0]        sqrem_q;
  logic [5:0]         cnt_q;
  logic [18:0]        dt;
  logic               dge;
  logic [20:0]        r2, trial;
  logic               sge;
  logic [16:0]        k;
  logic signed [26:0] px_q, py_q;
  logic [24:0]        pz_q;

  assign dx_s  = dx_q[slot_q];
  assign dy_s  = dy_q[slot_q];
  assign dx_e  = 18'(dx_s);
  assign dy_e  = 18'(dy_s);
  assign dt    = {rem_q, dd_q[34]};
  assign dge   = (dt >= {1'b0, s_q});
  assign r2    = {sqrem_q, q_q[35:34]};
  assign trial = {1'b0, root_q, 2'b01};
  assign sge   = (r2 >= trial);
  assign k     = 17'(({1'b0, root_q} + 19'd1) >> 1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      s_q     <= $unsigned(dx_e * dx_e) + $unsigned(dy_e * dy_e) + 18'(NORM_BASE);
      rem_q   <= DIV_REM_INIT;
      dd_q    <= DIV_LOW_BITS;
      q_q     <= '0;
      root_q  <= '0;
      sqrem_q <= '0;
      cnt_q   <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= dge ? 18'(dt - {1'b0, s_q}) : 18'(dt);
      dd_q  <= dd_q << 1;
      q_q   <= {q_q[34:0], dge};
      cnt_q <= sts_o.div_last ? '0 : cnt_q + 6'd1;
    end
    if (cmd_i.sqrt_step) begin
      sqrem_q <= sge ? 19'(r2 - trial) : 19'(r2);
      root_q  <= {root_q[16:0], sge};
      q_q     <= q_q << 2;
      cnt_q   <= cnt_q + 6'd1;
    end
    if (cmd_i.mul) begin
      px_q <= dx_s * $signed({1'b0, k});
      py_q <= dy_s * $signed({1'b0, k});
      pz_q <= 25'(k) * 25'd255;
    end
  end

  // Output register.
  function automatic logic [7:0] bias_byte(input logic signed [26:0] p);
    logic signed [27:0] num;
    num = $signed(28'(NORM_BIAS)) + 28'(p);
    if (num < 0) return 8'd0;
    if (num[27:17] > 11'd255) return 8'd255;
    return num[24:17];
  endfunction

  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      normal_x_o     <= bias_byte(px_q);
      normal_y_o     <= bias_byte(py_q);
      normal_z_o     <= pz_q[23:16];
      last_of_run_o  <= !sts_o.more;
      end_of_frame_o <= eof_q[slot_q];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign sts_o.row_zero  = (yc == '0);
  assign sts_o.div_last  = (cnt_q == 6'(DIV_STEPS - 1));
  assign sts_o.sqrt_last = (cnt_q == 6'(SQRT_STEPS - 1));
  assign sts_o.more      = ({1'b0, slot_q} + 3'd1) < {1'b0, n_q};
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

endmodule

// ----- hdl/height_to_normal_map.sv -----
// Height-to-normal-map converter. Heights arrive in raster order, one 8-bit
// sample per item, and each pixel yields a biased normal (x, y, z bytes)
// from central differences with the image borders clamped. Two line stores
// hold the previous and current rows, so results trail the input by one
// row; an item of the last row can release up to three results, and the
// final one an item releases is flagged with last_of_run_o. The
// bottom-right pixel carries end_of_frame_o. Items of the first row are
// only written into a line store while the controller stays idle. Every
// other item is accepted, then the line stores are read and written, and
// each of its results passes through the normalization unit: a setup step,
// a bit-serial divider, a bit-serial square root, a multiply and an output
// step. A finished result sits in an output register while the next one is
// computed; the output step waits while that register is still full.
// Writing image_width (index 0) or image_height (index 1) restarts the
// frame; sizes are saturated to 4..MAX_SIZE. The line stores need no
// clearing after reset, since every entry is written within a frame before
// it is read.
module height_to_normal_map #(
  parameter int unsigned MAX_SIZE = 128
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [htn_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [7:0]                    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    height_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [7:0]                    normal_x_o,
  output logic [7:0]                    normal_y_o,
  output logic [7:0]                    normal_z_o,
  output logic                          last_of_run_o,
  output logic                          end_of_frame_o
);
  import htn_pkg::*;

  htn_cmd_t cmd;
  htn_sts_t sts;

  // The controller sequences loads, the divider, the root and the output.
  htn_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // The datapath holds configuration, positions, line stores and arithmetic.
  htn_dp #(.MaxSize(MAX_SIZE)) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .height_i       (height_i),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .normal_x_o     (normal_x_o),
    .normal_y_o     (normal_y_o),
    .normal_z_o     (normal_z_o),
    .last_of_run_o  (last_of_run_o),
    .end_of_frame_o (end_of_frame_o),
    .cmd_i          (cmd),
    .sts_o          (sts)
  );

endmodule

// ----- verif/height_to_normal_map_test.sv -----
`timescale 1ns / 100ps

module height_to_normal_map_test;
  import htn_pkg::*;

  // Longest run we tolerate before declaring the block hung.
  localparam int unsigned CYCLE_LIMIT = 3000000;
  // Settle time after the last result, enough for three results to finish.
  localparam int unsigned DRAIN_CYCLES = 200;
  // An index beyond the two registers; a write there must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd2;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned IDLE_PERCENT = 29;

  typedef struct packed {
    logic [7:0] nx;
    logic [7:0] ny;
    logic [7:0] nz;
    logic       last;
    logic       eof;
  } normal_pixel_t;

  // Tracks the line stores and frame position of the block, and holds the
  // normal pixels each accepted height item is expected to release.
  class normal_scoreboard;
    logic [7:0]    older_row[128];
    logic [7:0]    newer_row[128];
    int unsigned   col;
    int unsigned   row;
    logic [7:0]    left_height;
    logic [7:0]    width_reg;
    logic [7:0]    height_reg;
    normal_pixel_t pending_normals[$];
    int unsigned   mismatches;

    function new();
      col = 0;
      row = 0;
      left_height = 8'd0;
      width_reg = CFG_SIZE_RESET;
      height_reg = CFG_SIZE_RESET;
      mismatches = 0;
      foreach (older_row[i]) begin
        older_row[i] = 8'd0;
        newer_row[i] = 8'd0;
      end
    endfunction

    function int unsigned clamp_size(logic [7:0] v);
      if (v < MIN_SIZE) return MIN_SIZE;
      if (v > 128) return 128;
      return v;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
      if (idx == CFG_IDX_WIDTH) width_reg = val;
      else if (idx == CFG_IDX_HEIGHT) height_reg = val;
      else return;
      col = 0;
      row = 0;
    endfunction

    // Largest k with (2k-1)^2 * s <= 4 * (255 * 2^16)^2, i.e. the rounded
    // value of 2^16 * 255 / sqrt(s).
    function longint unsigned scale_factor(longint unsigned s);
      longint unsigned lo, hi, mid, t, bound;
      bound = 64'd4 * 64'd16711680 * 64'd16711680;
      lo = 1;
      hi = 65536;
      while (lo < hi) begin
        mid = (lo + hi + 1) / 2;
        t = 2 * mid - 1;
        if (t * t * s <= bound) lo = mid;
        else hi = mid - 1;
      end
      return lo;
    endfunction

    function logic [7:0] biased(longint d, longint k);
      longint num, q;
      num = 64'sd16711680 + d * k;
      if (num < 0) return 8'd0;
      q = num / 131072;
      if (q > 255) q = 255;
      return q[7:0];
    endfunction

    function void push_normal(int l, int r, int u, int d, bit eof);
      normal_pixel_t p;
      longint dx, dy, k;
      dx = l - r;
      dy = u - d;
      k = scale_factor(dx * dx + dy * dy + 65025);
      p.nx = biased(dx, k);
      p.ny = biased(dy, k);
      p.nz = 8'((k * 255) / 65536);
      p.last = 1'b0;
      p.eof = eof;
      pending_normals.push_back(p);
    endfunction

    function void note_height(logic [7:0] v);
      int unsigned w, h, x, y, count;
      int c, up, lf, rt, cc, ll;
      w = clamp_size(width_reg);
      h = clamp_size(height_reg);
      x = (col >= w) ? w - 1 : col;
      y = (row >= h) ? h - 1 : row;
      count = 0;
      if (y == 0) begin
        newer_row[x] = v;
      end else begin
        c = newer_row[x];
        up = (y == 1) ? c : older_row[x];
        lf = (x == 0) ? c : left_height;
        rt = (x == w - 1) ? c : newer_row[x + 1];
        push_normal(lf, rt, up, v, 1'b0);
        count++;
        older_row[x] = c;
        left_height = c;
        newer_row[x] = v;
        // On the last row the pending row is finished off as well.
        if (y == h - 1) begin
          if (x >= 1) begin
            cc = newer_row[x - 1];
            ll = (x == 1) ? cc : newer_row[x - 2];
            push_normal(ll, v, older_row[x - 1], cc, 1'b0);
            count++;
          end
          if (x == w - 1) begin
            push_normal(newer_row[x - 1], v, older_row[x], v, 1'b1);
            count++;
          end
        end
      end
      if (count > 0) pending_normals[$].last = 1'b1;
      x++;
      if (x >= w) begin
        x = 0;
        y++;
        if (y >= h) y = 0;
      end
      col = x;
      row = y;
    endfunction

    function void check_normal(normal_pixel_t got);
      normal_pixel_t want;
      if (pending_normals.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected normal pixel: %h %h %h last=%b eof=%b",
                   got.nx, got.ny, got.nz, got.last, got.eof);
        return;
      end
      want = pending_normals.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"normal mismatch: expected x=%h y=%h z=%h last=%b eof=%b,",
                    " got x=%h y=%h z=%h last=%b eof=%b"},
                   want.nx, want.ny, want.nz, want.last, want.eof,
                   got.nx, got.ny, got.nz, got.last, got.eof);
      end
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [7:0]           cfg_data_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [7:0]           height_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [7:0]           normal_x_o;
  logic [7:0]           normal_y_o;
  logic [7:0]           normal_z_o;
  logic                 last_of_run_o;
  logic                 end_of_frame_o;

  normal_scoreboard sb;
  int unsigned      cycle_count;
  // While calm is set neither side idles; hold_request asks the receiver
  // for one long hold-off.
  bit               calm;
  bit               hold_request;

  height_to_normal_map dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .height_i(height_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .normal_x_o(normal_x_o),
    .normal_y_o(normal_y_o),
    .normal_z_o(normal_z_o),
    .last_of_run_o(last_of_run_o),
    .end_of_frame_o(end_of_frame_o)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("height_to_normal_map_test: done, errors");
      $finish;
    end
  end

  // Register write: one cycle with the write enable high. The predictor
  // takes the write at the same edge as the block. The caller drops the
  // write enable after its last write.
  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    sb.write_register(idx, val);
  endtask

  // Waits until every expected normal has arrived, then lets the block
  // finish any work that yields nothing further before the next write.
  task automatic wait_idle();
    while (sb.pending_normals.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Offers one height item, with random idle cycles ahead of it. The
  // handshake is judged from values sampled at the falling edge, which are
  // stable up to the next rising edge.
  task automatic send_height(logic [7:0] v);
    bit taken;
    while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    height_i <= v;
    do begin
      @(negedge clk_i);
      taken = in_ready_o;
      @(posedge clk_i);
    end while (!taken);
    sb.note_height(v);
  endtask

  // Random heights lean toward the extremes so the biased bytes clamp.
  function automatic logic [7:0] random_height();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic feed_random(int unsigned n);
    for (int unsigned i = 0; i < n; i++) send_height(random_height());
    in_valid_i <= 1'b0;
  endtask

  task automatic configure(logic [7:0] w, logic [7:0] h);
    wait_idle();
    write_register(CFG_IDX_WIDTH, w);
    write_register(CFG_IDX_HEIGHT, h);
    cfg_we_i <= 1'b0;
  endtask

  // Receiver: random stalls, plus one long hold-off on request so the
  // output register fills and the input side backs up.
  initial begin
    int unsigned hold_left;
    bit fire;
    normal_pixel_t got;
    hold_left = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      fire = out_valid_o && out_ready_i;
      got = '{normal_x_o, normal_y_o, normal_z_o, last_of_run_o, end_of_frame_o};
      @(posedge clk_i);
      if (fire) sb.check_normal(got);
      if (!rst_ni) begin
        out_ready_i <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_OFF_CYCLES;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
    end
  end

  initial begin
    int unsigned w, h, n;
    sb = new();
    cycle_count = 0;
    calm = 1'b0;
    hold_request = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = CFG_IDX_WIDTH;
    cfg_data_i = 8'd0;
    in_valid_i = 1'b0;
    height_i = 8'd0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset sizes (32 x 32): the first row, then part of the second.
    feed_random(40);

    // Smallest frame with a checkerboard of extreme heights, which drives
    // every difference to its limits at edges, top and bottom rows.
    configure(8'd4, 8'd4);
    for (int unsigned i = 0; i < 16; i++)
      send_height((((i % 4) ^ (i / 4)) & 1) ? 8'hFF : 8'h00);
    in_valid_i <= 1'b0;

    // Out-of-range sizes saturate to the minimum; a write to an unused
    // index must change nothing, not even the frame position.
    configure(8'd0, 8'd3);
    feed_random(5);
    wait_idle();
    write_register(CFG_IDX_SPARE, 8'hA5);
    cfg_we_i <= 1'b0;
    feed_random(11);

    // Widest rows with no idling on either side and one long hold-off:
    // the first row, then part of the second.
    configure(8'd200, 8'd4);
    calm = 1'b1;
    hold_request = 1'b1;
    feed_random(128 + 32);
    calm = 1'b0;

    // Narrowest rows in a tall frame.
    configure(8'd4, 8'd255);
    feed_random(40);

    // Small random frames, some cut short by the next register write.
    for (int unsigned p = 0; p < 2; p++) begin
      w = $urandom_range(4, 10);
      h = $urandom_range(4, 8);
      n = w * h;
      if ($urandom_range(0, 2) == 0) n = n - $urandom_range(1, w);
      configure(8'(w), 8'(h));
      feed_random(n);
    end

    wait_idle();
    if (sb.mismatches == 0 && sb.pending_normals.size() == 0) begin
      $display("height_to_normal_map_test: done, clean");
    end else begin
      $display("height_to_normal_map_test: done, errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/htn_pkg.sv
hdl/htn_ram.sv
hdl/htn_ctrl.sv
hdl/htn_dp.sv
hdl/height_to_normal_map.sv
verif/height_to_normal_map_test.sv
